// ----- rtl/ssr_pkg.sv -----
// ----------------------------------------------------------------------------
// ssr_pkg: shared types and constants for the subset-sum reachability block
// Transaction structs, mode codes, state encoding and the byte popcount.
// ----------------------------------------------------------------------------
package ssr_pkg;

  // Default sizing of the sum store and of the value operand
  localparam int SumBitsDefault   = 17;
  localparam int ValueBitsDefault = 12;

  // Store word organization: 64-bit words, 6-bit bit index inside a word
  localparam int WordW   = 64;
  localparam int BitIdxW = 6;

  // Fixed field widths of the transactions
  localparam int CoinW  = 12;
  localparam int QueryW = 17;
  localparam int CountW = 17;
  localparam int AddedW = 10;

  localparam logic [CountW-1:0] CountMax = '1;
  localparam logic [AddedW-1:0] AddedMax = '1;

  // Mode codes of an input transaction
  localparam logic ModeAdd   = 1'b0;
  localparam logic ModeQuery = 1'b1;

  typedef struct packed {
    logic              mode;
    logic [CoinW-1:0]  coin_value;
    logic [QueryW-1:0] query_sum;
  } ssr_in_t;

  typedef struct packed {
    logic              reachable;
    logic [CountW-1:0] distinct_sums;
    logic              overflowed;
    logic [AddedW-1:0] values_added;
  } ssr_out_t;

  typedef enum logic [2:0] {
    StClear,
    StIdle,
    StSweep,
    StDrain,
    StQuery,
    StDone
  } ssr_state_e;

  // Count set bits of one byte
  function automatic logic [3:0] pop8(logic [7:0] b);
    logic [3:0] c;
    c = '0;
    for (int k = 0; k < 8; k++) begin
      c = c + 4'(b[k]);
    end
    return c;
  endfunction

endpackage

// ----- rtl/ssr_ram.sv -----
// ----------------------------------------------------------------------------
// ssr_ram: generic memory, one write port and two registered read ports
// Read data is registered and appears in the cycle after the address.
// ----------------------------------------------------------------------------
module ssr_ram #(
  parameter int Width = 64,
  parameter int Depth = 2048
) (
  input  logic                     clk_i,
  input  logic                     we_i,
  input  logic [$clog2(Depth)-1:0] waddr_i,
  input  logic [Width-1:0]         wdata_i,
  input  logic [$clog2(Depth)-1:0] raddr_a_i,
  output logic [Width-1:0]         rdata_a_o,
  input  logic [$clog2(Depth)-1:0] raddr_b_i,
  output logic [Width-1:0]         rdata_b_o
);

  logic [Width-1:0] mem_q [Depth];

  // Write one word, read two words
  always_ff @(posedge clk_i) begin
    if (we_i) begin
      mem_q[waddr_i] <= wdata_i;
    end
    rdata_a_o <= mem_q[raddr_a_i];
    rdata_b_o <= mem_q[raddr_b_i];
  end

endmodule

// ----- rtl/subset_sum_reachability.sv -----
// ----------------------------------------------------------------------------
// subset_sum_reachability: bitmap of sums reachable by subsets of added values
// Add transactions OR the bitmap with itself shifted up by the value; query
// transactions test one sum. Every transaction returns one result.
// ----------------------------------------------------------------------------
//
//   Channel  Handshake                 Payload
//   -------  ------------------------  -------------------------------------
//   input    in_valid_i / in_ready_o   in_i  (mode, coin_value, query_sum)
//   output   out_valid_o / out_ready_i out_o (reachable, distinct_sums,
//                                             overflowed, values_added)
//
// During an add the sweep moves one 64-bit store word per cycle through the
// single RAM write port. A query passes through StQuery to StDone; an add of
// zero or of a value beyond the store goes straight to StDone.
// After reset a clearing pass writes every store word.
// The result sits in an output register; input is taken again while it waits.
// One transaction is in work at a time; in_ready_o is low until it finishes.
module subset_sum_reachability #(
  parameter int SUM_BITS   = ssr_pkg::SumBitsDefault,
  parameter int VALUE_BITS = ssr_pkg::ValueBitsDefault
) (
  input  logic             clk_i,
  input  logic             rst_ni,
  input  logic             in_valid_i,
  output logic             in_ready_o,
  input  ssr_pkg::ssr_in_t in_i,
  output logic             out_valid_o,
  input  logic             out_ready_i,
  output ssr_pkg::ssr_out_t out_o
);

  localparam int WordW = ssr_pkg::WordW;
  localparam int IdxW  = ssr_pkg::BitIdxW;
  localparam int WA    = SUM_BITS - IdxW;
  localparam int CntW  = ssr_pkg::CountW;

  ssr_pkg::ssr_state_e state_q, state_d;

  logic [WA-1:0]     clr_q, clr_d;
  logic [WA-1:0]     ra_q, ra_d;
  logic [WA-1:0]     rb_q, rb_d;
  logic              rb_ok_q, rb_ok_d;
  logic              prime_q, prime_d;

  logic              iss_a, iss_prime;
  logic              s1_vld_q, s1_prime_q, s1_lo_ok_q;
  logic [WA-1:0]     s1_addr_q;
  logic              s2_vld_q, s3_vld_q;

  logic [WordW-1:0]  hi_q, fresh_q;
  logic [3:0]        bc_q [WordW/8];
  logic [IdxW-1:0]   bs_q, tb_q, qbit_q;
  logic [WA-1:0]     tw_q;
  logic              qok_q, reach_q;

  logic [CntW-1:0]   count_q, count_d;
  logic              ovf_q;
  logic [ssr_pkg::AddedW-1:0] added_q;

  logic              out_valid_q;
  ssr_pkg::ssr_out_t out_q;

  // Input decode
  logic [VALUE_BITS-1:0] val;
  logic [SUM_BITS-1:0]   val_s, thr, q_ext;
  logic                  val_big, q_range, in_acc, add_acc, load_out;

  assign val     = VALUE_BITS'(in_i.coin_value);
  assign val_s   = SUM_BITS'(val);
  assign val_big = (32'(val) >> SUM_BITS) != 32'd0;
  assign thr     = SUM_BITS'(0) - val_s;
  assign q_ext   = SUM_BITS'(in_i.query_sum);
  assign q_range = (32'(in_i.query_sum) >> SUM_BITS) == 32'd0;
  assign in_acc  = in_valid_i && in_ready_o;
  assign add_acc = in_acc && (in_i.mode == ssr_pkg::ModeAdd);

  // RAM ports
  logic             we;
  logic [WA-1:0]    waddr, raddr_a;
  logic [WordW-1:0] wdata, rd_a, rd_b;

  ssr_ram #(
    .Width (WordW),
    .Depth (1 << WA)
  ) u_ssr_ram (
    .clk_i     (clk_i),
    .we_i      (we),
    .waddr_i   (waddr),
    .wdata_i   (wdata),
    .raddr_a_i (raddr_a),
    .rdata_a_o (rd_a),
    .raddr_b_i (rb_q),
    .rdata_b_o (rd_b)
  );

  // Shift-merge unit: new word = old | (store shifted up by the value)
  logic [WordW-1:0]   lo, sh, merged, fresh;
  logic [2*WordW-1:0] shifted;
  logic               drop;

  always_comb begin
    lo      = s1_lo_ok_q ? rd_b : '0;
    shifted = {hi_q, lo} << bs_q;
    sh      = shifted[2*WordW-1:WordW];
    merged  = rd_a | sh;
    fresh   = sh & ~rd_a;
    drop    = s1_vld_q &&
              (((s1_addr_q > tw_q) && (rd_a != '0)) ||
               ((s1_addr_q == tw_q) && ((rd_a >> tb_q) != '0)));
  end

  // Sum byte counts of the newly set bits into the saturating count
  logic [6:0]      pop_sum;
  logic [CntW:0]   count_ext;

  always_comb begin
    pop_sum = '0;
    for (int k = 0; k < WordW/8; k++) begin
      pop_sum = pop_sum + 7'(bc_q[k]);
    end
    count_ext = {1'b0, count_q} + (CntW+1)'(pop_sum);
    count_d   = count_q;
    if (s3_vld_q) begin
      count_d = (count_ext > (CntW+1)'(ssr_pkg::CountMax)) ?
                ssr_pkg::CountMax : count_ext[CntW-1:0];
    end
  end

  // Sequencer: next state, pointers and RAM control
  always_comb begin
    state_d    = state_q;
    clr_d      = clr_q;
    ra_d       = ra_q;
    rb_d       = rb_q;
    rb_ok_d    = rb_ok_q;
    prime_d    = prime_q;
    iss_a      = 1'b0;
    iss_prime  = 1'b0;
    in_ready_o = 1'b0;
    load_out   = 1'b0;
    raddr_a    = ra_q;
    we         = s1_vld_q;
    waddr      = s1_addr_q;
    wdata      = merged;
    case (state_q)
      ssr_pkg::StClear: begin
        we    = 1'b1;
        waddr = clr_q;
        wdata = WordW'(clr_q == '0);
        if (clr_q == '1) begin
          state_d = ssr_pkg::StIdle;
        end else begin
          clr_d = clr_q + 1'b1;
        end
      end
      ssr_pkg::StIdle: begin
        in_ready_o = 1'b1;
        raddr_a    = q_ext[SUM_BITS-1:IdxW];
        if (in_valid_i) begin
          if (in_i.mode == ssr_pkg::ModeQuery) begin
            state_d = ssr_pkg::StQuery;
          end else if (val == '0 || val_big) begin
            state_d = ssr_pkg::StDone;
          end else begin
            state_d = ssr_pkg::StSweep;
            ra_d    = '1;
            rb_d    = ~val_s[SUM_BITS-1:IdxW];
            rb_ok_d = 1'b1;
            prime_d = 1'b1;
          end
        end
      end
      ssr_pkg::StSweep: begin
        iss_a     = !prime_q;
        iss_prime = prime_q;
        rb_ok_d   = rb_ok_q && (rb_q != '0);
        rb_d      = rb_q - 1'b1;
        if (prime_q) begin
          prime_d = 1'b0;
        end else if (ra_q == '0) begin
          state_d = ssr_pkg::StDrain;
        end else begin
          ra_d = ra_q - 1'b1;
        end
      end
      ssr_pkg::StDrain: begin
        if (!(s1_vld_q || s1_prime_q || s2_vld_q || s3_vld_q)) begin
          state_d = ssr_pkg::StDone;
        end
      end
      ssr_pkg::StQuery: begin
        state_d = ssr_pkg::StDone;
      end
      ssr_pkg::StDone: begin
        if (!out_valid_q || out_ready_i) begin
          load_out = 1'b1;
          state_d  = ssr_pkg::StIdle;
        end
      end
      default: begin
        state_d = ssr_pkg::StIdle;
      end
    endcase
  end

  // Control and state registers
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q     <= ssr_pkg::StClear;
      clr_q       <= '0;
      ra_q        <= '0;
      rb_q        <= '0;
      rb_ok_q     <= 1'b0;
      prime_q     <= 1'b0;
      s1_vld_q    <= 1'b0;
      s1_prime_q  <= 1'b0;
      s1_lo_ok_q  <= 1'b0;
      s2_vld_q    <= 1'b0;
      s3_vld_q    <= 1'b0;
      count_q     <= '0;
      ovf_q       <= 1'b0;
      added_q     <= '0;
      out_valid_q <= 1'b0;
    end else begin
      state_q    <= state_d;
      clr_q      <= clr_d;
      ra_q       <= ra_d;
      rb_q       <= rb_d;
      rb_ok_q    <= rb_ok_d;
      prime_q    <= prime_d;
      s1_vld_q   <= iss_a;
      s1_prime_q <= iss_prime;
      s1_lo_ok_q <= (iss_a || iss_prime) && rb_ok_q;
      s2_vld_q   <= s1_vld_q;
      s3_vld_q   <= s2_vld_q;
      count_q    <= count_d;
      // Flag dropped sums: value beyond the store, or shifted past the top
      if ((add_acc && val_big) || drop) begin
        ovf_q <= 1'b1;
      end
      if (add_acc && added_q != ssr_pkg::AddedMax) begin
        added_q <= added_q + 1'b1;
      end
      if (load_out) begin
        out_valid_q <= 1'b1;
      end else if (out_ready_i) begin
        out_valid_q <= 1'b0;
      end
    end
  end

  // Datapath registers
  always_ff @(posedge clk_i) begin
    s1_addr_q <= ra_q;
    if (s1_vld_q || s1_prime_q) begin
      hi_q <= lo;
    end
    fresh_q <= fresh;
    for (int k = 0; k < WordW/8; k++) begin
      bc_q[k] <= ssr_pkg::pop8(fresh_q[8*k +: 8]);
    end
    if (in_acc) begin
      bs_q    <= val_s[IdxW-1:0];
      tw_q    <= thr[SUM_BITS-1:IdxW];
      tb_q    <= thr[IdxW-1:0];
      qbit_q  <= q_ext[IdxW-1:0];
      qok_q   <= q_range && (q_ext != '0);
      reach_q <= 1'b0;
    end else if (state_q == ssr_pkg::StQuery) begin
      reach_q <= qok_q && rd_a[qbit_q];
    end
    if (load_out) begin
      out_q.reachable     <= reach_q;
      out_q.distinct_sums <= count_q;
      out_q.overflowed    <= ovf_q;
      out_q.values_added  <= added_q;
    end
  end

  assign out_valid_o = out_valid_q;
  assign out_o       = out_q;

endmodule

// ----- rtl/ssr_checker.sv -----
// ----------------------------------------------------------------------------
// ssr_checker: port-level checks for the subset-sum reachability block
// Watches both channels and tracks accepted transactions and past results.
// ----------------------------------------------------------------------------
module ssr_checker (
  input logic              clk_i,
  input logic              rst_ni,
  input logic              in_valid_i,
  input logic              in_ready_o,
  input ssr_pkg::ssr_in_t  in_i,
  input logic              out_valid_o,
  input logic              out_ready_i,
  input ssr_pkg::ssr_out_t out_o
);

  logic [1:0]                  pend_q;
  logic                        seen_ovf_q;
  logic [ssr_pkg::AddedW-1:0]  last_added_q;
  logic [ssr_pkg::CountW-1:0]  last_count_q;
  logic                        in_acc, out_acc;

  assign in_acc  = in_valid_i && in_ready_o;
  assign out_acc = out_valid_o && out_ready_i;

  // Track outstanding transactions and the last delivered result
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      pend_q       <= '0;
      seen_ovf_q   <= 1'b0;
      last_added_q <= '0;
      last_count_q <= '0;
    end else begin
      pend_q <= pend_q + 2'(in_acc) - 2'(out_acc);
      if (out_acc) begin
        seen_ovf_q   <= seen_ovf_q | out_o.overflowed;
        last_added_q <= out_o.values_added;
        last_count_q <= out_o.distinct_sums;
      end
    end
  end

  // Hold a stalled result unchanged
  a_out_hold: assert property (@(posedge clk_i) disable iff (!rst_ni)
    out_valid_o && !out_ready_i |=> out_valid_o && $stable(out_o))
    else $error("result changed or dropped while stalled");

  // Show a result only for an accepted transaction
  a_no_invent: assert property (@(posedge clk_i) disable iff (!rst_ni)
    out_valid_o |-> pend_q != 2'd0)
    else $error("result without an accepted transaction");

  // Keep the overflow flag once reported
  a_ovf_sticky: assert property (@(posedge clk_i) disable iff (!rst_ni)
    out_valid_o && seen_ovf_q |-> out_o.overflowed)
    else $error("overflow flag cleared");

  // Never let the counts go backward
  a_monotonic: assert property (@(posedge clk_i) disable iff (!rst_ni)
    out_valid_o |-> (out_o.values_added >= last_added_q) &&
                    (out_o.distinct_sums >= last_count_q))
    else $error("count decreased");

endmodule

bind subset_sum_reachability ssr_checker u_ssr_checker (
  .clk_i       (clk_i),
  .rst_ni      (rst_ni),
  .in_valid_i  (in_valid_i),
  .in_ready_o  (in_ready_o),
  .in_i        (in_i),
  .out_valid_o (out_valid_o),
  .out_ready_i (out_ready_i),
  .out_o       (out_o)
);

// ----- verif/tb.sv -----
// ----------------------------------------------------------------------------
// tb: self-checking testbench for subset_sum_reachability
// Drives add and query transactions through the valid/ready input channel and
// predicts every result from a word-organized copy of the reachable-sum
// bitmap. A scoreboard class holds the prediction and checks each result in
// order. The stimulus runs in phases: a directed opening, random traffic with
// queries aimed at reachable sums, a fill that drives the count to its limit,
// and a short tail of zero-value adds mixed with queries.
// ----------------------------------------------------------------------------
module tb;

  localparam int          SumBits     = ssr_pkg::SumBitsDefault;
  localparam int          ValueBits   = ssr_pkg::ValueBitsDefault;
  localparam int          WordW       = ssr_pkg::WordW;
  localparam int          BitIdxW     = ssr_pkg::BitIdxW;
  localparam int unsigned StoreSize   = 1 << SumBits;
  localparam int          Words       = StoreSize / WordW;
  localparam int unsigned ValueMask   = (1 << ValueBits) - 1;
  localparam int unsigned CycleLimit  = 3_000_000;
  localparam int          DrainCycles = 2100;
  localparam int          RandomItems = 200;
  localparam int          TailItems   = 10;

  // Reachable-sum predictor and in-order result checker
  class reach_scoreboard;
    logic [WordW-1:0]  sum_words [Words];
    int unsigned       sum_count;
    logic              flag_overflow;
    int unsigned       add_total;
    ssr_pkg::ssr_out_t pending_results [$];
    int unsigned       fail_count;

    function new();
      foreach (sum_words[i]) sum_words[i] = '0;
      sum_words[0][0] = 1'b1;
      sum_count     = 0;
      flag_overflow = 1'b0;
      add_total     = 0;
      fail_count    = 0;
    endfunction

    // True if some reachable sum plus v lands at or past the top of the store
    function bit drops_past_top(int unsigned v);
      for (int w = Words - 1; w >= 0; w--) begin
        if (sum_words[w] != '0) begin
          for (int b = WordW - 1; b >= 0; b--) begin
            if (sum_words[w][b]) return (w * WordW + b + v) >= StoreSize;
          end
        end
      end
      return 1'b0;
    endfunction

    // OR the bitmap with itself shifted up by v, counting newly set sums
    function void add_coin(int unsigned v);
      int unsigned    fresh;
      int             ws;
      int             bs;
      int             src;
      logic [127:0]   pair;
      logic [WordW-1:0] moved;
      if (v == 0) return;
      if (v >= StoreSize || drops_past_top(v)) flag_overflow = 1'b1;
      if (v >= StoreSize) return;
      ws    = v >> BitIdxW;
      bs    = v % WordW;
      fresh = 0;
      // walk top down so every source word is read before it is updated
      for (int i = Words - 1; i >= 0; i--) begin
        src  = i - ws;
        pair = '0;
        if (src >= 0) pair[127:64] = sum_words[src];
        if (src >= 1) pair[63:0] = sum_words[src - 1];
        pair  = pair << bs;
        moved = pair[127:64];
        fresh += $countones(moved & ~sum_words[i]);
        sum_words[i] |= moved;
      end
      if (sum_count + fresh > ssr_pkg::CountMax) sum_count = ssr_pkg::CountMax;
      else sum_count = sum_count + fresh;
    endfunction

    function logic sum_is_reachable(int unsigned q);
      if (q == 0 || q >= StoreSize) return 1'b0;
      return sum_words[q >> BitIdxW][q % WordW];
    endfunction

    // Random nonzero reachable sum, or zero when only the empty sum exists
    function int unsigned pick_reachable();
      int               w;
      int               b;
      logic [WordW-1:0] cand;
      w = $urandom_range(0, Words - 1);
      for (int n = 0; n < Words; n++) begin
        cand = sum_words[w];
        if (w == 0) cand[0] = 1'b0;
        if (cand != '0) begin
          b = $urandom_range(0, WordW - 1);
          while (!cand[b]) b = (b + 1) % WordW;
          return w * WordW + b;
        end
        w = (w + 1) % Words;
      end
      return 0;
    endfunction

    // Record an accepted input transaction and queue its expected result
    function void note_input(ssr_pkg::ssr_in_t item);
      ssr_pkg::ssr_out_t r;
      r = '0;
      if (item.mode == ssr_pkg::ModeAdd) begin
        add_coin(int'(item.coin_value) & ValueMask);
        if (add_total < ssr_pkg::AddedMax) add_total++;
      end else begin
        r.reachable = sum_is_reachable(item.query_sum);
      end
      r.distinct_sums = ssr_pkg::CountW'(sum_count);
      r.overflowed    = flag_overflow;
      r.values_added  = ssr_pkg::AddedW'(add_total);
      pending_results.push_back(r);
    endfunction

    task report(string msg);
      $display("mismatch: %s", msg);
      fail_count++;
    endtask

    // Compare one result transaction against the oldest expectation
    task check_result(ssr_pkg::ssr_out_t got);
      ssr_pkg::ssr_out_t want;
      if (pending_results.size() == 0) begin
        report($sformatf("result with nothing pending (sums %0d)", got.distinct_sums));
        return;
      end
      want = pending_results.pop_front();
      if (got.reachable !== want.reachable)
        report($sformatf("reachable got %0b want %0b", got.reachable, want.reachable));
      if (got.distinct_sums !== want.distinct_sums)
        report($sformatf("distinct_sums got %0d want %0d",
                         got.distinct_sums, want.distinct_sums));
      if (got.overflowed !== want.overflowed)
        report($sformatf("overflowed got %0b want %0b", got.overflowed, want.overflowed));
      if (got.values_added !== want.values_added)
        report($sformatf("values_added got %0d want %0d",
                         got.values_added, want.values_added));
    endtask
  endclass

  logic              clk_i       = 1'b0;
  logic              rst_ni      = 1'b0;
  logic              in_valid_i  = 1'b0;
  logic              in_ready_o;
  ssr_pkg::ssr_in_t  in_i        = '0;
  logic              out_valid_o;
  logic              out_ready_i = 1'b0;
  ssr_pkg::ssr_out_t out_o;

  reach_scoreboard sb;
  bit              steady;
  int unsigned     cycle_count;
  int unsigned     taken_count;
  int unsigned     taken_seen;
  int unsigned     rx_hold;

  subset_sum_reachability u_dut (
    .clk_i      (clk_i),
    .rst_ni     (rst_ni),
    .in_valid_i (in_valid_i),
    .in_ready_o (in_ready_o),
    .in_i       (in_i),
    .out_valid_o(out_valid_o),
    .out_ready_i(out_ready_i),
    .out_o      (out_o)
  );

  always #10 clk_i = ~clk_i;

  // Abort a hung run
  always @(posedge clk_i) begin
    cycle_count <= cycle_count + 1;
    if (cycle_count == CycleLimit) begin
      $display("FAIL subset_sum_reachability");
      $finish;
    end
  end

  // Check each result transaction as it is taken
  always @(posedge clk_i) begin
    if (rst_ni && out_valid_o && out_ready_i) begin
      sb.check_result(out_o);
      taken_count <= taken_count + 1;
    end
  end

  // Stall the result side for a random number of cycles after each transaction
  always @(negedge clk_i) begin
    if (taken_count != taken_seen) begin
      taken_seen = taken_count;
      rx_hold    = steady ? 0 : $urandom_range(0, 7);
    end
    if (rx_hold != 0) begin
      out_ready_i <= 1'b0;
      rx_hold--;
    end else begin
      out_ready_i <= 1'b1;
    end
  end

  function automatic ssr_pkg::ssr_in_t mk_add(int unsigned v);
    ssr_pkg::ssr_in_t t;
    t.mode       = ssr_pkg::ModeAdd;
    t.coin_value = ssr_pkg::CoinW'(v);
    t.query_sum  = ssr_pkg::QueryW'($urandom);
    return t;
  endfunction

  function automatic ssr_pkg::ssr_in_t mk_query(int unsigned q);
    ssr_pkg::ssr_in_t t;
    t.mode       = ssr_pkg::ModeQuery;
    t.coin_value = ssr_pkg::CoinW'($urandom);
    t.query_sum  = ssr_pkg::QueryW'(q);
    return t;
  endfunction

  // Offer one transaction, hold it until taken; leave valid high for the next
  task automatic send_item(ssr_pkg::ssr_in_t item);
    int gap;
    gap = steady ? 0 : $urandom_range(0, 7);
    if (gap != 0) begin
      in_valid_i <= 1'b0;
      repeat (gap) @(negedge clk_i);
    end
    in_i       <= item;
    in_valid_i <= 1'b1;
    do @(posedge clk_i); while (!in_ready_o);
    sb.note_input(item);
    @(negedge clk_i);
  endtask

  task automatic run_directed();
    send_item(mk_query(0));
    send_item(mk_query(StoreSize - 1));
    send_item(mk_query(1));
    send_item(mk_add(0));
    send_item(mk_query(0));
    send_item(mk_add(1));
    send_item(mk_query(1));
    send_item(mk_add(ValueMask));
    send_item(mk_query(ValueMask));
    send_item(mk_query(ValueMask + 1));
    send_item(mk_query(ValueMask + 2));
    send_item(mk_add(1));
    send_item(mk_query(2));
    send_item(mk_add(64));
    send_item(mk_add(63));
    send_item(mk_add(2048));
    send_item(mk_query(2048 + 64 + 63 + 1));
    send_item(mk_query(StoreSize - 1));
    send_item(mk_add(0));
    send_item(mk_query(sb.pick_reachable()));
  endtask

  function automatic ssr_pkg::ssr_in_t random_item();
    int unsigned r;
    int unsigned q;
    r = $urandom_range(0, 99);
    if (r < 40) begin
      // aim at a reachable sum or one of its neighbors
      q = sb.pick_reachable();
      if ($urandom_range(0, 9) == 0) q = (q + $urandom_range(0, 2) + StoreSize - 1) % StoreSize;
      return mk_query(q);
    end
    if (r < 55) return mk_query($urandom_range(0, StoreSize - 1));
    if (r < 60) return mk_query($urandom_range(0, 1) ? 0 : StoreSize - 1 - $urandom_range(0, 3));
    if (r < 72) return mk_add($urandom_range(1, 300));
    if (r < 85) return mk_add($urandom_range(0, ValueMask));
    return mk_add(0);
  endfunction

  task automatic run_random();
    for (int n = 0; n < RandomItems; n++) begin
      if ($urandom_range(0, 29) == 0) steady = ~steady;
      send_item(random_item());
    end
    steady = 1'b0;
  endtask

  // Drive the bitmap full: powers of two cover a dense base, then max steps
  task automatic run_fill();
    int guard;
    for (int k = 0; k < ValueBits; k++) send_item(mk_add(1 << k));
    guard = 0;
    while (sb.sum_count < ssr_pkg::CountMax && guard < 40) begin
      send_item(mk_add(ValueMask));
      if ($urandom_range(0, 2) == 0) send_item(mk_query(sb.pick_reachable()));
      guard++;
    end
    send_item(mk_query(StoreSize - 1));
    send_item(mk_query(1));
    send_item(mk_query(0));
    send_item(mk_add(ValueMask));
  endtask

  // Finish with a short mix of zero-value adds and queries
  task automatic run_tail();
    for (int n = 0; n < TailItems; n++) begin
      if ($urandom_range(0, 99) < 30) begin
        send_item(mk_query($urandom_range(0, StoreSize - 1)));
      end else begin
        send_item(mk_add(0));
      end
    end
  endtask

  initial begin
    sb     = new();
    steady = 1'b0;
    repeat (11) @(negedge clk_i);
    rst_ni <= 1'b1;

    run_directed();
    run_random();
    run_fill();
    run_tail();
    in_valid_i <= 1'b0;

    // wait out every pending result, then let the block settle
    while (sb.pending_results.size() != 0) @(posedge clk_i);
    repeat (DrainCycles) @(posedge clk_i);

    if (sb.fail_count == 0) begin
      $display("PASS subset_sum_reachability");
    end else begin
      $display("FAIL subset_sum_reachability");
    end
    $finish;
  end

endmodule
